// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the biquad cascade RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SBQT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SBQT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sbqt_pkg.sv
// Shared constants, types and saturation helper for the biquad cascade.
// No dependencies; used by the interfaces and every RTL module but sbqt_ram.
`default_nettype none

package sbqt_pkg;

    localparam int MAX_SECTIONS_DEF   = 8;
    localparam int COEF_FRAC_BITS_DEF = 28;

    localparam int SAMPLE_W   = 24;
    localparam int MID_W      = 32;
    localparam int DELAY_W    = 48;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = 64;
    localparam int GUARD_BITS = 16;
    localparam int TRIM_W     = 24;
    localparam int TRIM_FRAC  = 20;
    localparam int NCOEF      = 5;

    localparam int MODE_W     = 2;
    localparam int CSEC_W     = 3;
    localparam int CSLOT_W    = 3;
    localparam int SECT_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PH_W       = 3;

    localparam logic [TRIM_W-1:0] TRIM_UNITY = TRIM_W'(1 << TRIM_FRAC);

    localparam logic signed [PROD_W-1:0] Y_ROUND    = 64'sd1 <<< (GUARD_BITS - 1);
    localparam logic signed [PROD_W-1:0] TRIM_ROUND = 64'sd1 <<< (TRIM_FRAC - 1);

    // request modes
    localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COEF  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTIONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM     = 2'd2;

    localparam logic [CSLOT_W-1:0] SLOT_LIMIT = CSLOT_W'(NCOEF);

    // section phases; phases up to PH_A2 also read coefficient slot = phase
    localparam logic [PH_W-1:0] PH_B0  = 3'd0;
    localparam logic [PH_W-1:0] PH_B1  = 3'd1;
    localparam logic [PH_W-1:0] PH_ACC = 3'd2;
    localparam logic [PH_W-1:0] PH_Y   = 3'd3;
    localparam logic [PH_W-1:0] PH_A2  = 3'd4;
    localparam logic [PH_W-1:0] PH_D1  = 3'd5;
    localparam logic [PH_W-1:0] PH_D2  = 3'd6;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEC      = 5'b00010,
        ST_TRIM_MUL = 5'b00100,
        ST_TRIM_RES = 5'b01000,
        ST_DONE     = 5'b10000
    } t_state;

    typedef struct packed {
        logic load_frame;
        logic load_right;
        logic pass;
        logic clear;
        logic sel_y;
        logic sel_trim;
        logic acc_b0;
        logic y_load;
        logic d2n_load;
        logic d1_write;
        logic d2_write;
        logic trim_out;
        logic chan;
    } t_dp_ctrl;

    function automatic logic signed [PROD_W-1:0] sat_w(
        input logic signed [PROD_W-1:0] v,
        input int bits
    );
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = ~hi;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sbqt_if.sv
// Valid/ready channel interfaces: request input, result output, config write.
// Depends on sbqt_pkg for field widths.
`default_nettype none

interface sbqt_in_if;
    import sbqt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic [CSEC_W-1:0]          coef_section;
    logic [CSLOT_W-1:0]         coef_slot;
    logic signed [COEF_W-1:0]   coef_value;

    modport source (output valid, mode, left_in, right_in, coef_section, coef_slot,
                    coef_value, input ready);
    modport sink (input valid, mode, left_in, right_in, coef_section, coef_slot,
                  coef_value, output ready);
endinterface

interface sbqt_out_if;
    import sbqt_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, left_out, right_out, input ready);
    modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sbqt_cfg_if;
    import sbqt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sbqt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sbqt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/sbqt_dp.sv
// Datapath: shared 32x32 multiplier, accumulate/saturate logic, delay registers.
// Depends on sbqt_pkg; driven by sbqt_ctrl.
`default_nettype none

module sbqt_dp #(
    parameter int MAX_SECTIONS   = sbqt_pkg::MAX_SECTIONS_DEF,
    parameter int COEF_FRAC_BITS = sbqt_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire sbqt_pkg::t_dp_ctrl                           i_ctrl,
    input  wire logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] i_sec,
    input  wire logic signed [sbqt_pkg::SAMPLE_W-1:0]         i_left,
    input  wire logic signed [sbqt_pkg::SAMPLE_W-1:0]         i_right,
    input  wire logic signed [sbqt_pkg::COEF_W-1:0]           i_coef,
    input  wire logic [sbqt_pkg::TRIM_W-1:0]                  i_trim,
    output logic signed [sbqt_pkg::SAMPLE_W-1:0]              o_res_l,
    output logic signed [sbqt_pkg::SAMPLE_W-1:0]              o_res_r
);
    import sbqt_pkg::*;

    localparam int PSHIFT = COEF_FRAC_BITS - GUARD_BITS;
    localparam int SUM_W  = PROD_W - PSHIFT + 2;

    logic signed [MID_W-1:0]    r_x;
    logic signed [MID_W-1:0]    r_right;
    logic signed [MID_W-1:0]    r_y;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [DELAY_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]    r_d1n;
    logic signed [SUM_W-1:0]    r_d2n;
    logic signed [DELAY_W-1:0]  r_d1 [MAX_SECTIONS][2];
    logic signed [DELAY_W-1:0]  r_d2 [MAX_SECTIONS][2];
    logic signed [SAMPLE_W-1:0] r_res_l;
    logic signed [SAMPLE_W-1:0] r_res_r;

    logic signed [COEF_W-1:0]  mul_a;
    logic signed [MID_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [DELAY_W-1:0] d1_cur;
    logic signed [DELAY_W-1:0] d2_cur;
    logic signed [PROD_W-1:0]  acc_full;
    logic signed [PROD_W-1:0]  y_full;
    logic signed [PROD_W-1:0]  d1n_sum;
    logic signed [PROD_W-1:0]  d1_full;
    logic signed [PROD_W-1:0]  d2_full;
    logic signed [PROD_W-1:0]  trim_full;

    always_comb begin
        mul_a     = i_ctrl.sel_trim ? signed'({{(COEF_W - TRIM_W){1'b0}}, i_trim}) : i_coef;
        mul_b     = i_ctrl.sel_y ? r_y : r_x;
        n_prod    = mul_a * mul_b;
        prod_sh   = r_prod >>> PSHIFT;
        d1_cur    = r_d1[i_sec][i_ctrl.chan];
        d2_cur    = r_d2[i_sec][i_ctrl.chan];
        acc_full  = sat_w(prod_sh + PROD_W'(d1_cur), DELAY_W);
        y_full    = sat_w((PROD_W'(r_acc) + Y_ROUND) >>> GUARD_BITS, MID_W);
        d1n_sum   = prod_sh + PROD_W'(d2_cur);
        d1_full   = sat_w(PROD_W'(r_d1n) - prod_sh, DELAY_W);
        d2_full   = sat_w(PROD_W'(r_d2n) - prod_sh, DELAY_W);
        trim_full = sat_w((r_prod + TRIM_ROUND) >>> TRIM_FRAC, SAMPLE_W);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (i_ctrl.load_frame) begin
            r_x     <= MID_W'(i_left);
            r_right <= MID_W'(i_right);
        end else if (i_ctrl.load_right) begin
            r_x <= r_right;
        end else if (i_ctrl.d2_write) begin
            // section output feeds the next section
            r_x <= r_y;
        end
        if (i_ctrl.acc_b0) begin
            r_acc <= acc_full[DELAY_W-1:0];
        end
        if (i_ctrl.y_load) begin
            r_y   <= y_full[MID_W-1:0];
            r_d1n <= d1n_sum[SUM_W-1:0];
        end
        if (i_ctrl.d2n_load) begin
            r_d2n <= prod_sh[SUM_W-1:0];
        end
        if (i_ctrl.pass) begin
            r_res_l <= i_left;
            r_res_r <= i_right;
        end else if (i_ctrl.trim_out) begin
            if (i_ctrl.chan) begin
                r_res_r <= trim_full[SAMPLE_W-1:0];
            end else begin
                r_res_l <= trim_full[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int s = 0; s < MAX_SECTIONS; s++) begin
                for (int c = 0; c < 2; c++) begin
                    r_d1[s][c] <= '0;
                    r_d2[s][c] <= '0;
                end
            end
        end else begin
            if (i_ctrl.d1_write) begin
                r_d1[i_sec][i_ctrl.chan] <= d1_full[DELAY_W-1:0];
            end
            if (i_ctrl.d2_write) begin
                r_d2[i_sec][i_ctrl.chan] <= d2_full[DELAY_W-1:0];
            end
        end
    end

    assign o_res_l = r_res_l;
    assign o_res_r = r_res_r;

endmodule

`default_nettype wire

// File: hw/rtl/sbqt_ctrl.sv
// Sequencer: walks channels, sections and the seven phases of each section,
// issues coefficient reads and datapath strobes. Depends on sbqt_pkg.
`default_nettype none

module sbqt_ctrl #(
    parameter int MAX_SECTIONS = sbqt_pkg::MAX_SECTIONS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_acc,
    input  wire logic [sbqt_pkg::MODE_W-1:0]      i_mode,
    input  wire logic                             i_enable,
    input  wire logic [sbqt_pkg::SECT_W-1:0]      i_sections,
    input  wire logic                             i_out_free,
    output logic                                  o_in_ready,
    output logic                                  o_out_load,
    output sbqt_pkg::t_dp_ctrl                    o_dp,
    output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] o_sec,
    output logic [$clog2(MAX_SECTIONS * sbqt_pkg::NCOEF)-1:0]          o_raddr
);
    import sbqt_pkg::*;

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int AW    = $clog2(MAX_SECTIONS * NCOEF);

    t_state           r_state, n_state;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic [CNT_W-1:0] r_sec, n_sec;
    logic [CNT_W-1:0] r_nsec, n_nsec;
    logic             r_chan, n_chan;
    logic [CNT_W-1:0] sec_inc;
    logic [CNT_W-1:0] nsec_clamp;
    logic [PH_W-1:0]  slot;

    always_comb begin
        sec_inc    = r_sec + CNT_W'(1);
        nsec_clamp = (int'(i_sections) > MAX_SECTIONS) ? CNT_W'(MAX_SECTIONS)
                                                       : CNT_W'(i_sections);
        slot       = (r_phase > PH_A2) ? PH_A2 : r_phase;
        o_raddr    = AW'(AW'(r_sec) * AW'(NCOEF) + AW'(slot));
        o_sec      = r_sec[SEC_W-1:0];
        o_in_ready = (r_state == ST_IDLE);
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_sec      = r_sec;
        n_nsec     = r_nsec;
        n_chan     = r_chan;
        o_dp       = '0;
        o_dp.chan  = r_chan;
        o_out_load = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_acc) begin
                    unique case (i_mode)
                        MODE_FRAME: begin
                            if (i_enable) begin
                                o_dp.load_frame = 1'b1;
                                n_chan  = 1'b0;
                                n_sec   = '0;
                                n_phase = PH_B0;
                                n_nsec  = nsec_clamp;
                                n_state = (nsec_clamp == '0) ? ST_TRIM_MUL : ST_SEC;
                            end else begin
                                o_dp.pass = 1'b1;
                                n_state   = ST_DONE;
                            end
                        end
                        MODE_CLEAR: o_dp.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SEC: begin
                n_phase = r_phase + PH_W'(1);
                unique case (r_phase)
                    PH_B0, PH_B1: ;
                    PH_ACC: o_dp.acc_b0 = 1'b1;
                    PH_Y:   o_dp.y_load = 1'b1;
                    PH_A2: begin
                        o_dp.d2n_load = 1'b1;
                        o_dp.sel_y    = 1'b1;
                    end
                    PH_D1: begin
                        o_dp.d1_write = 1'b1;
                        o_dp.sel_y    = 1'b1;
                    end
                    PH_D2: begin
                        o_dp.d2_write = 1'b1;
                        n_sec   = sec_inc;
                        n_phase = PH_B0;
                        if (sec_inc == r_nsec) begin
                            n_state = ST_TRIM_MUL;
                        end
                    end
                    default: n_phase = PH_B0;
                endcase
            end
            ST_TRIM_MUL: begin
                o_dp.sel_trim = 1'b1;
                n_state       = ST_TRIM_RES;
            end
            ST_TRIM_RES: begin
                o_dp.trim_out = 1'b1;
                if (!r_chan) begin
                    // advance to the right channel
                    o_dp.load_right = 1'b1;
                    n_chan  = 1'b1;
                    n_sec   = '0;
                    n_phase = PH_B0;
                    n_state = (r_nsec == '0) ? ST_TRIM_MUL : ST_SEC;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_B0;
            r_sec   <= '0;
            r_nsec  <= '0;
            r_chan  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_sec   <= n_sec;
            r_nsec  <= n_nsec;
            r_chan  <= n_chan;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/stereo_biquad_cascade_with_trim.sv
// Channel   | Dir | Carries
// ----------+-----+-----------------------------------------------------
// i_cfg     | in  | register index and data: enable, sections, trim gain
// i_in      | in  | request: stereo frame, coefficient write, delay clear
// o_out     | out | filtered, trimmed, saturated stereo frame
//
// An enabled frame runs n sections per channel, taking no request meanwhile, n being
// the sections in use capped at MAX_SECTIONS: the single 32x32 multiplier does
// five products per section in a seven-phase loop, per channel, plus trim.
// A disabled frame goes straight to ST_DONE; coefficient writes and clears stay in ST_IDLE.
// Reset (i_rst_n low, synchronous) zeroes all delays; coefficients stay unset.
// The result waits in an output register, so the next request is taken while
// o_out stalls; a finished frame holds only if that register is still full.
// Depends on sbqt_pkg, sbqt_if, sbqt_ram, sbqt_dp, sbqt_ctrl, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module stereo_biquad_cascade_with_trim #(
    parameter int MAX_SECTIONS   = sbqt_pkg::MAX_SECTIONS_DEF,
    parameter int COEF_FRAC_BITS = sbqt_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbqt_cfg_if.sink   i_cfg,
    sbqt_in_if.sink    i_in,
    sbqt_out_if.source o_out
);
    import sbqt_pkg::*;

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int DEPTH = MAX_SECTIONS * NCOEF;
    localparam int AW    = $clog2(DEPTH);

    logic                       r_enable;
    logic [SECT_W-1:0]          r_sections;
    logic [TRIM_W-1:0]          r_trim;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;

    logic                       cfg_acc;
    logic                       in_acc;
    logic                       in_ready;
    logic                       out_free;
    logic                       out_load;
    logic                       coef_we;
    logic [AW-1:0]              coef_waddr;
    logic [AW-1:0]              coef_raddr;
    logic signed [COEF_W-1:0]   coef_rdata;
    t_dp_ctrl                   dp_ctrl;
    logic [SEC_W-1:0]           sec;
    logic signed [SAMPLE_W-1:0] res_l;
    logic signed [SAMPLE_W-1:0] res_r;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = in_ready;
    assign in_acc      = i_in.valid && in_ready;
    assign out_free    = !r_out_valid || o_out.ready;

    // drop coefficient writes aimed outside the table
    assign coef_we    = in_acc && (i_in.mode == MODE_COEF)
                        && (int'(i_in.coef_section) < MAX_SECTIONS)
                        && (i_in.coef_slot < SLOT_LIMIT);
    assign coef_waddr = AW'(AW'(i_in.coef_section) * AW'(NCOEF) + AW'(i_in.coef_slot));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_sections <= '0;
            r_trim     <= TRIM_UNITY;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                REG_ENABLE:   r_enable   <= i_cfg.data[0];
                REG_SECTIONS: r_sections <= i_cfg.data[SECT_W-1:0];
                REG_TRIM:     r_trim     <= i_cfg.data[TRIM_W-1:0];
                default: ;
            endcase
        end
    end

    sbqt_ram #(
        .WIDTH (COEF_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in.coef_value),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    sbqt_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (in_acc),
        .i_mode     (i_in.mode),
        .i_enable   (r_enable),
        .i_sections (r_sections),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_out_load (out_load),
        .o_dp       (dp_ctrl),
        .o_sec      (sec),
        .o_raddr    (coef_raddr)
    );

    sbqt_dp #(
        .MAX_SECTIONS   (MAX_SECTIONS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (dp_ctrl),
        .i_sec   (sec),
        .i_left  (i_in.left_in),
        .i_right (i_in.right_in),
        .i_coef  (coef_rdata),
        .i_trim  (r_trim),
        .o_res_l (res_l),
        .o_res_r (res_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    `SBQT_ASSERT_NXT(a_frame_busy, i_clk, i_rst_n, in_acc && (i_in.mode == MODE_FRAME), !in_ready, "frame accepted but block still ready")
    `SBQT_ASSERT_IMP(a_load_free, i_clk, i_rst_n, out_load, !r_out_valid || o_out.ready, "result loaded over an undelivered result")
    `SBQT_ASSERT_IMP(a_result_busy, i_clk, i_rst_n, $rose(r_out_valid), !$past(in_ready), "result appeared without a frame in work")

endmodule

`default_nettype wire

// File: bench/biquad_result_checker.sv
// Result checker for the stereo biquad cascade: tracks coefficients, delays and
// settings from the accepted requests and checks every result frame in order.
// Depends on sbqt_pkg and the channel interfaces in sbqt_if.
module biquad_result_checker (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbqt_in_if          i_in,
    sbqt_out_if         i_out,
    sbqt_cfg_if         i_cfg,
    output int unsigned o_pending,
    output int unsigned o_failures
);
    timeunit 1ns;
    timeprecision 1ps;
    import sbqt_pkg::*;

    localparam int TAP_COUNT     = MAX_SECTIONS_DEF * NCOEF;
    localparam int DELAY_COUNT   = MAX_SECTIONS_DEF * 2;
    localparam int PRODUCT_SHIFT = COEF_FRAC_BITS_DEF - GUARD_BITS;

    localparam int TAP_B0 = 0;
    localparam int TAP_B1 = 1;
    localparam int TAP_B2 = 2;
    localparam int TAP_A1 = 3;
    localparam int TAP_A2 = 4;

    localparam int CHAN_LEFT  = 0;
    localparam int CHAN_RIGHT = 1;

    typedef struct {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_stereo;

    longint              coef_bank [TAP_COUNT];
    longint              z1 [DELAY_COUNT];
    longint              z2 [DELAY_COUNT];
    logic                filter_on;
    logic [SECT_W-1:0]   active_sections;
    logic [TRIM_W-1:0]   trim;
    t_stereo             expected_frames [$];

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // floor the Q4.28 product into the Q32.16 delay format
    function automatic longint coef_product(input longint c, input longint x);
        return (c * x) >>> PRODUCT_SHIFT;
    endfunction

    function automatic void clear_delays();
        foreach (z1[i]) begin
            z1[i] = 0;
            z2[i] = 0;
        end
    endfunction

    function automatic longint filter_channel(input longint x, input int chan, input int count);
        longint acc;
        longint y;
        longint sig;
        int     base;
        int     d;
        sig = x;
        for (int s = 0; s < count; s++) begin
            base = s * NCOEF;
            d    = s * 2 + chan;
            acc  = clamp(coef_product(coef_bank[base + TAP_B0], sig) + z1[d], DELAY_W);
            y    = clamp((acc + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS, MID_W);
            z1[d] = clamp(coef_product(coef_bank[base + TAP_B1], sig)
                          - coef_product(coef_bank[base + TAP_A1], y) + z2[d], DELAY_W);
            z2[d] = clamp(coef_product(coef_bank[base + TAP_B2], sig)
                          - coef_product(coef_bank[base + TAP_A2], y), DELAY_W);
            sig = y;
        end
        return clamp((sig * longint'(trim) + (longint'(1) <<< (TRIM_FRAC - 1))) >>> TRIM_FRAC,
                     SAMPLE_W);
    endfunction

    always @(posedge i_clk) begin
        t_stereo want;
        longint  l;
        longint  r;
        int      n;
        if (!i_rst_n) begin
            foreach (coef_bank[i]) coef_bank[i] = 0;
            clear_delays();
            filter_on       = 1'b0;
            active_sections = '0;
            trim            = TRIM_UNITY;
            expected_frames.delete();
            o_failures      = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected result: left_out %0d, right_out %0d",
                           i_out.left_out, i_out.right_out);
                    o_failures++;
                end else begin
                    want = expected_frames.pop_front();
                    if (i_out.left_out !== want.left) begin
                        $error("left_out: expected %0d, actual %0d",
                               $signed(want.left), i_out.left_out);
                        o_failures++;
                    end
                    if (i_out.right_out !== want.right) begin
                        $error("right_out: expected %0d, actual %0d",
                               $signed(want.right), i_out.right_out);
                        o_failures++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ENABLE:   filter_on       = i_cfg.data[0];
                    REG_SECTIONS: active_sections = i_cfg.data[SECT_W-1:0];
                    REG_TRIM:     trim            = i_cfg.data[TRIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.mode)
                    MODE_FRAME: begin
                        l = longint'(i_in.left_in);
                        r = longint'(i_in.right_in);
                        if (filter_on) begin
                            n = (active_sections > MAX_SECTIONS_DEF) ? MAX_SECTIONS_DEF
                                                                     : int'(active_sections);
                            l = filter_channel(l, CHAN_LEFT, n);
                            r = filter_channel(r, CHAN_RIGHT, n);
                        end
                        want.left  = l[SAMPLE_W-1:0];
                        want.right = r[SAMPLE_W-1:0];
                        expected_frames.insert(expected_frames.size(), want);
                    end
                    MODE_COEF: begin
                        if (i_in.coef_slot < SLOT_LIMIT
                                && int'(i_in.coef_section) < MAX_SECTIONS_DEF) begin
                            coef_bank[int'(i_in.coef_section) * NCOEF + int'(i_in.coef_slot)] =
                                longint'(i_in.coef_value);
                        end
                    end
                    MODE_CLEAR: clear_delays();
                    default: ;
                endcase
            end
        end
        o_pending = expected_frames.size();
    end

endmodule

// File: bench/stereo_biquad_cascade_with_trim_test.sv
// Top of the biquad cascade bench: clock, reset, request and settings traffic,
// output stalls and the verdict. Depends on sbqt_pkg, sbqt_if, the block and
// biquad_result_checker.
module stereo_biquad_cascade_with_trim_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sbqt_pkg::*;

    localparam int     HALF_PERIOD    = 5;
    localparam longint LIMIT_NS       = 30_000_000;
    localparam int     RANDOM_ITEMS   = 1150;
    localparam int     SETTLE_CYCLES  = 16;
    localparam int     FINAL_CYCLES   = 256;
    localparam int     LONG_HOLD      = 600;

    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(64'd1 << COEF_FRAC_BITS_DEF);

    typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned pending;
    int unsigned failures;

    sbqt_in_if  in_ch ();
    sbqt_out_if out_ch ();
    sbqt_cfg_if cfg_ch ();

    stereo_biquad_cascade_with_trim i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    biquad_result_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg      (cfg_ch),
        .o_pending  (pending),
        .o_failures (failures)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // sender shaping
    int unsigned burst_left = 0;
    int unsigned burst_max  = 8;
    int unsigned gap_max    = 4;
    int unsigned work_items = 0;
    bit          coef_loaded [MAX_SECTIONS_DEF * NCOEF];

    // receiver shaping
    t_rx_style   rx_style      = RX_MOSTLY;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left     = 0;
    int unsigned rx_tick       = 0;

    logic signed [COEF_W-1:0] identity_taps [NCOEF];
    logic signed [COEF_W-1:0] extreme_taps  [NCOEF];

    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            hold_left     = LONG_HOLD;
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_FREE:   out_ch.ready <= 1'b1;
                RX_MOSTLY: out_ch.ready <= ($urandom_range(9) < 7);
                RX_SPARSE: out_ch.ready <= ($urandom_range(9) < 3);
                default:   out_ch.ready <= ((rx_tick % 5) < 3);
            endcase
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("stereo_biquad_cascade_with_trim_test failed");
        $finish;
    end

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(4095)) - 2048);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // keep most sections near stable so the cascade does not just pin to the rails
    function automatic logic signed [COEF_W-1:0] random_coef();
        int span;
        if ($urandom_range(4) == 0) return COEF_W'($urandom);
        span = int'(COEF_ONE) / 2;
        return COEF_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_noise(input logic [CFG_DATA_W-1:0] value,
                                                        input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (CFG_DATA_W'(1) << width) - 1;
        if ($urandom_range(1) == 0) return value;
        return (CFG_DATA_W'($urandom) & ~keep) | value;
    endfunction

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic signed [SAMPLE_W-1:0] left, right,
                                input logic [CSEC_W-1:0] section,
                                input logic [CSLOT_W-1:0] slot,
                                input logic signed [COEF_W-1:0] value);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(gap_max, 1)) @(negedge i_clk);
            end
            burst_left = $urandom_range(burst_max, 1);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.left_in      <= left;
        in_ch.right_in     <= right;
        in_ch.coef_section <= section;
        in_ch.coef_slot    <= slot;
        in_ch.coef_value   <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        work_items++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left, right);
        send_request(MODE_FRAME, left, right, CSEC_W'($urandom), CSLOT_W'($urandom),
                     COEF_W'($urandom));
    endtask

    task automatic send_coef(input logic [CSEC_W-1:0] section, input logic [CSLOT_W-1:0] slot,
                             input logic signed [COEF_W-1:0] value);
        send_request(MODE_COEF, random_sample(), random_sample(), section, slot, value);
        if (slot < SLOT_LIMIT) begin
            coef_loaded[int'(section) * NCOEF + int'(slot)] = 1'b1;
        end
    endtask

    task automatic send_other(input logic [MODE_W-1:0] mode);
        send_request(mode, random_sample(), random_sample(), CSEC_W'($urandom),
                     CSLOT_W'($urandom), COEF_W'($urandom));
    endtask

    // hold the request channel low until every result is in, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // fill every coefficient that an enabled frame with this many sections will read
    task automatic apply_settings(input logic en, input logic [SECT_W-1:0] sections,
                                  input logic [TRIM_W-1:0] gain);
        int used;
        drain();
        write_reg(REG_ENABLE, with_noise(CFG_DATA_W'(en), 1));
        write_reg(REG_SECTIONS, with_noise(CFG_DATA_W'(sections), SECT_W));
        write_reg(REG_TRIM, CFG_DATA_W'(gain));
        used = (sections > MAX_SECTIONS_DEF) ? MAX_SECTIONS_DEF : int'(sections);
        if (en) begin
            for (int s = 0; s < used; s++) begin
                for (int k = 0; k < NCOEF; k++) begin
                    if (!coef_loaded[s * NCOEF + k]) send_coef(CSEC_W'(s), CSLOT_W'(k), random_coef());
                end
            end
        end
    endtask

    initial begin
        logic              en;
        logic [SECT_W-1:0] sections;
        logic [TRIM_W-1:0] gain;
        int unsigned       phase;
        int unsigned       count;
        int unsigned       pick;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_FRAME;
        in_ch.left_in      = '0;
        in_ch.right_in     = '0;
        in_ch.coef_section = '0;
        in_ch.coef_slot    = '0;
        in_ch.coef_value   = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_ENABLE;
        cfg_ch.data        = '0;
        out_ch.ready       = 1'b0;
        identity_taps      = '{COEF_ONE, '0, '0, '0, '0};
        extreme_taps       = '{COEF_MAX, COEF_MIN, COEF_ONE, COEF_MIN, COEF_MAX};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pass-through after reset, ignored requests, then a plain and an extreme section
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame('0, '1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_other(MODE_UNUSED);
        send_other(MODE_CLEAR);
        for (int k = NCOEF; k < (1 << CSLOT_W); k++) begin
            send_coef(CSEC_W'($urandom), CSLOT_W'(k), COEF_W'($urandom));
        end
        for (int k = 0; k < NCOEF; k++) send_coef(CSEC_W'(0), CSLOT_W'(k), identity_taps[k]);
        for (int k = 0; k < NCOEF; k++) send_coef(CSEC_W'(1), CSLOT_W'(k), extreme_taps[k]);

        apply_settings(1'b1, '0, '1);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_W'(1), '1);
        apply_settings(1'b1, SECT_W'(1), TRIM_UNITY);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        apply_settings(1'b1, SECT_W'(2), TRIM_UNITY);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);
        send_frame(SAMPLE_MIN, SAMPLE_MAX);
        send_other(MODE_CLEAR);
        send_frame(SAMPLE_MAX, SAMPLE_MIN);

        work_items = 0;
        phase      = 0;
        while (work_items < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    en = 1'b1;
                    sections = '1;
                    gain = '1;
                end
                1: begin
                    en = 1'b1;
                    sections = SECT_W'(MAX_SECTIONS_DEF);
                    gain = '0;
                end
                2: begin
                    en = 1'b0;
                    sections = SECT_W'($urandom);
                    gain = TRIM_W'($urandom);
                end
                default: begin
                    en = ($urandom_range(5) != 0);
                    case ($urandom_range(5))
                        0:       sections = '0;
                        1:       sections = '1;
                        2:       sections = SECT_W'($urandom_range(15, MAX_SECTIONS_DEF));
                        default: sections = SECT_W'($urandom_range(4, 1));
                    endcase
                    case ($urandom_range(5))
                        0:       gain = '0;
                        1:       gain = '1;
                        2:       gain = TRIM_UNITY;
                        3:       gain = TRIM_W'($urandom);
                        default: gain = TRIM_W'($urandom_range(int'(TRIM_UNITY) * 3 / 2,
                                                               int'(TRIM_UNITY) / 2));
                    endcase
                end
            endcase
            apply_settings(en, sections, gain);

            case ($urandom_range(3))
                0: begin
                    gap_max   = 0;
                    burst_max = 1000;
                end
                1: begin
                    gap_max   = 3;
                    burst_max = 4;
                end
                default: begin
                    gap_max   = 12;
                    burst_max = 20;
                end
            endcase
            rx_style = t_rx_style'($urandom_range(3));

            // hold results back while requests keep coming, so the block backs up
            if (phase == 0 || $urandom_range(3) == 0) hold_requests++;

            count = $urandom_range(120, 40);
            for (int i = 0; i < count; i++) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    send_frame(random_sample(), random_sample());
                end else if (pick < 88) begin
                    send_coef(CSEC_W'($urandom), CSLOT_W'($urandom_range(NCOEF - 1)),
                              random_coef());
                end else if (pick < 91) begin
                    send_coef(CSEC_W'($urandom),
                              CSLOT_W'($urandom_range((1 << CSLOT_W) - 1, NCOEF)),
                              COEF_W'($urandom));
                end else if (pick < 95) begin
                    send_other(MODE_CLEAR);
                end else begin
                    send_other(MODE_UNUSED);
                end
                if (i == count / 2 && $urandom_range(2) == 0) drain();
            end
            phase++;
        end

        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (FINAL_CYCLES) @(negedge i_clk);
        if (failures == 0) begin
            $display("stereo_biquad_cascade_with_trim_test passed");
        end else begin
            $display("stereo_biquad_cascade_with_trim_test failed");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/sbqt_pkg.sv
hw/rtl/sbqt_if.sv
hw/rtl/sbqt_ram.sv
hw/rtl/sbqt_dp.sv
hw/rtl/sbqt_ctrl.sv
hw/rtl/stereo_biquad_cascade_with_trim.sv
bench/biquad_result_checker.sv
bench/stereo_biquad_cascade_with_trim_test.sv
